// ===== sv/assert_macros.svh =====
// Assertion macros shared by the ALU modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/c16alu_pkg.sv =====
// Types, opcodes and constants of the 16-bit basic-opcode ALU.
package c16alu_pkg;

  localparam int WORD_W         = 16;
  localparam int DIV_BITS_STEP  = 4;
  localparam int DIV_STEPS      = (2 * WORD_W) / DIV_BITS_STEP;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 40;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0,
    OP_SET = 5'd1,
    OP_ADD = 5'd2,
    OP_SUB = 5'd3,
    OP_MUL = 5'd4,
    OP_MLI = 5'd5,
    OP_DIV = 5'd6,
    OP_DVI = 5'd7,
    OP_MOD = 5'd8,
    OP_MDI = 5'd9,
    OP_AND = 5'd10,
    OP_BOR = 5'd11,
    OP_XOR = 5'd12,
    OP_SHR = 5'd13,
    OP_ASR = 5'd14,
    OP_SHL = 5'd15,
    OP_IFB = 5'd16,
    OP_IFC = 5'd17,
    OP_IFE = 5'd18,
    OP_IFN = 5'd19,
    OP_IFG = 5'd20,
    OP_IFA = 5'd21,
    OP_IFL = 5'd22,
    OP_IFU = 5'd23,
    OP_ADX = 5'd26,
    OP_SBX = 5'd27,
    OP_STI = 5'd30,
    OP_STD = 5'd31
  } opcode_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE,
    CLS_MUL,
    CLS_DIV
  } op_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic div_start;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    op_class_t op_class;
    logic      div_last;
    logic      out_free;
  } dp_stat_t;

endpackage

// ===== sv/c16alu_div.sv =====
// Iterative restoring divider, 32-bit dividend by 16-bit divisor.
module c16alu_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           step,
  input  logic [2*c16alu_pkg::WORD_W-1:0] dividend,
  input  logic [c16alu_pkg::WORD_W-1:0]   divisor,
  output logic [2*c16alu_pkg::WORD_W-1:0] quotient,
  output logic [c16alu_pkg::WORD_W-1:0]   remainder,
  output logic                           last
);
  import c16alu_pkg::*;

  logic [2*WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0]   rem_r, rem_nxt;
  logic [WORD_W-1:0]   dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  always_comb begin
    logic [WORD_W:0]     part;
    logic [2*WORD_W-1:0] q;
    logic [WORD_W-1:0]   r;
    q = quo_r;
    r = rem_r;
    for (int i = 0; i < DIV_BITS_STEP; i++) begin
      part = {r, q[2*WORD_W-1]};
      q    = {q[2*WORD_W-2:0], 1'b0};
      if (part >= {1'b0, dsr_r}) begin
        part = part - {1'b0, dsr_r};
        q[0] = 1'b1;
      end
      r = part[WORD_W-1:0];
    end
    quo_nxt = q;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign last      = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

// ===== sv/c16alu_dp.sv =====
// Datapath: operand registers, multiplier, divider, result select, EX and output register.
module c16alu_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [c16alu_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  c16alu_pkg::dp_cmd_t                 cmd,
  output c16alu_pkg::dp_stat_t                stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [c16alu_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import c16alu_pkg::*;
  `include "assert_macros.svh"

  opcode_t             op_r;
  logic [WORD_W-1:0]   b_r, a_r;
  logic [WORD_W-1:0]   ex_r, ex_nxt;
  logic [2*WORD_W-1:0] prod_r;

  logic                out_tvalid_r;
  logic [WORD_W-1:0]   res_b_r, res_b_nxt;
  logic                wr_r, wr_nxt;
  logic                skip_r, skip_nxt;
  logic [WORD_W-1:0]   res_ex_r;
  logic [1:0]          step_r, step_nxt;
  logic [1:0]          cost_r, cost_nxt;

  logic                mul_signed;
  logic signed [WORD_W:0]     mul_x, mul_y;
  logic signed [2*WORD_W+1:0] mul_full;

  logic                div_signed, div_mod, a_zero;
  logic [WORD_W-1:0]   b_mag, a_mag;
  logic [2*WORD_W-1:0] div_dividend, div_q;
  logic [WORD_W-1:0]   div_divisor, div_rem;
  logic                div_last;

  logic [WORD_W:0]     add_sum;
  logic [WORD_W+1:0]   adx_sum, sbx_sum;
  logic                sh_big;
  logic [2*WORD_W-1:0] shr_v, shl_v;
  logic signed [2*WORD_W-1:0] asr_v;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode_t'(in_tdata[4:0]);
      b_r  <= in_tdata[20:5];
      a_r  <= in_tdata[36:21];
    end
    if (cmd.capture) begin
      prod_r <= mul_full[2*WORD_W-1:0];
    end
  end

  always_comb begin
    stat.div_last = div_last;
    stat.out_free = !out_tvalid_r || out_tready;
    case (op_r)
      OP_MUL, OP_MLI: stat.op_class = CLS_MUL;
      OP_DIV, OP_DVI, OP_MOD, OP_MDI: stat.op_class = CLS_DIV;
      default: stat.op_class = CLS_SIMPLE;
    endcase
  end

  assign mul_signed = (op_r == OP_MLI);
  assign mul_x      = {mul_signed & b_r[WORD_W-1], b_r};
  assign mul_y      = {mul_signed & a_r[WORD_W-1], a_r};
  assign mul_full   = mul_x * mul_y;

  assign div_signed   = (op_r == OP_DVI) || (op_r == OP_MDI);
  assign div_mod      = (op_r == OP_MOD) || (op_r == OP_MDI);
  assign a_zero       = (a_r == '0);
  assign b_mag        = (div_signed && b_r[WORD_W-1]) ? (~b_r + 1'b1) : b_r;
  assign a_mag        = (div_signed && a_r[WORD_W-1]) ? (~a_r + 1'b1) : a_r;
  assign div_dividend = div_mod ? {{WORD_W{1'b0}}, b_mag} : {b_mag, {WORD_W{1'b0}}};
  assign div_divisor  = a_mag;

  c16alu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .step      (cmd.div_step),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_q),
    .remainder (div_rem),
    .last      (div_last)
  );

  assign add_sum = {1'b0, b_r} + {1'b0, a_r};
  assign adx_sum = {2'b0, b_r} + {2'b0, a_r} + {2'b0, ex_r};
  assign sbx_sum = {2'b0, b_r} - {2'b0, a_r} + {{2{ex_r[WORD_W-1]}}, ex_r};
  assign sh_big  = |a_r[WORD_W-1:5];
  assign shr_v   = sh_big ? '0 : ({b_r, {WORD_W{1'b0}}} >> a_r[4:0]);
  assign shl_v   = sh_big ? '0 : ({{WORD_W{1'b0}}, b_r} << a_r[4:0]);
  assign asr_v   = sh_big ? $signed({(2*WORD_W){b_r[WORD_W-1]}})
                          : ($signed({b_r, {WORD_W{1'b0}}}) >>> a_r[4:0]);

  always_comb begin
    res_b_nxt = b_r;
    wr_nxt    = 1'b1;
    skip_nxt  = 1'b0;
    ex_nxt    = ex_r;
    step_nxt  = STEP_NONE;
    cost_nxt  = 2'd1;
    case (op_r)
      OP_SET: res_b_nxt = a_r;
      OP_ADD: begin
        res_b_nxt = add_sum[WORD_W-1:0];
        ex_nxt    = {{(WORD_W-1){1'b0}}, add_sum[WORD_W]};
        cost_nxt  = 2'd2;
      end
      OP_SUB: begin
        res_b_nxt = b_r - a_r;
        ex_nxt    = (b_r < a_r) ? '1 : '0;
        cost_nxt  = 2'd2;
      end
      OP_MUL, OP_MLI: begin
        res_b_nxt = prod_r[WORD_W-1:0];
        ex_nxt    = prod_r[2*WORD_W-1:WORD_W];
        cost_nxt  = 2'd2;
      end
      OP_DIV: begin
        res_b_nxt = a_zero ? '0 : div_q[2*WORD_W-1:WORD_W];
        ex_nxt    = a_zero ? '0 : div_q[WORD_W-1:0];
        cost_nxt  = 2'd3;
      end
      OP_DVI: begin
        if (a_zero) begin
          res_b_nxt = '0;
          ex_nxt    = '0;
        end else if (b_r[WORD_W-1] ^ a_r[WORD_W-1]) begin
          res_b_nxt = ~div_q[2*WORD_W-1:WORD_W] + 1'b1;
          ex_nxt    = ~div_q[WORD_W-1:0] + 1'b1;
        end else begin
          res_b_nxt = div_q[2*WORD_W-1:WORD_W];
          ex_nxt    = div_q[WORD_W-1:0];
        end
        cost_nxt = 2'd3;
      end
      OP_MOD: begin
        res_b_nxt = a_zero ? '0 : div_rem;
        cost_nxt  = 2'd3;
      end
      OP_MDI: begin
        if (a_zero) begin
          res_b_nxt = '0;
        end else if (b_r[WORD_W-1]) begin
          res_b_nxt = ~div_rem + 1'b1;
        end else begin
          res_b_nxt = div_rem;
        end
        cost_nxt = 2'd3;
      end
      OP_AND: res_b_nxt = b_r & a_r;
      OP_BOR: res_b_nxt = b_r | a_r;
      OP_XOR: res_b_nxt = b_r ^ a_r;
      OP_SHR: begin
        res_b_nxt = shr_v[2*WORD_W-1:WORD_W];
        ex_nxt    = shr_v[WORD_W-1:0];
      end
      OP_ASR: begin
        res_b_nxt = asr_v[2*WORD_W-1:WORD_W];
        ex_nxt    = asr_v[WORD_W-1:0];
      end
      OP_SHL: begin
        res_b_nxt = shl_v[WORD_W-1:0];
        ex_nxt    = shl_v[2*WORD_W-1:WORD_W];
      end
      OP_IFB: begin
        wr_nxt   = 1'b0;
        skip_nxt = ((b_r & a_r) == '0);
        cost_nxt = 2'd2;
      end
      OP_IFC: begin
        wr_nxt   = 1'b0;
        skip_nxt = ((b_r & a_r) != '0);
        cost_nxt = 2'd2;
      end
      OP_IFE: begin
        wr_nxt   = 1'b0;
        skip_nxt = (b_r != a_r);
        cost_nxt = 2'd2;
      end
      OP_IFN: begin
        wr_nxt   = 1'b0;
        skip_nxt = (b_r == a_r);
        cost_nxt = 2'd2;
      end
      OP_IFG: begin
        wr_nxt   = 1'b0;
        skip_nxt = (b_r <= a_r);
        cost_nxt = 2'd2;
      end
      OP_IFA: begin
        wr_nxt   = 1'b0;
        skip_nxt = ($signed(b_r) <= $signed(a_r));
        cost_nxt = 2'd2;
      end
      OP_IFL: begin
        wr_nxt   = 1'b0;
        skip_nxt = (b_r >= a_r);
        cost_nxt = 2'd2;
      end
      OP_IFU: begin
        wr_nxt   = 1'b0;
        skip_nxt = ($signed(b_r) >= $signed(a_r));
        cost_nxt = 2'd2;
      end
      OP_ADX: begin
        res_b_nxt = adx_sum[WORD_W-1:0];
        ex_nxt    = (adx_sum[WORD_W+1:WORD_W] != 2'b00) ? WORD_W'(1) : '0;
        cost_nxt  = 2'd2;
      end
      OP_SBX: begin
        res_b_nxt = sbx_sum[WORD_W-1:0];
        if (sbx_sum[WORD_W+1]) begin
          ex_nxt = '1;
        end else if (sbx_sum[WORD_W]) begin
          ex_nxt = WORD_W'(1);
        end else begin
          ex_nxt = '0;
        end
        cost_nxt = 2'd2;
      end
      OP_STI: begin
        res_b_nxt = a_r;
        step_nxt  = STEP_INC;
        cost_nxt  = 2'd0;
      end
      OP_STD: begin
        res_b_nxt = a_r;
        step_nxt  = STEP_DEC;
        cost_nxt  = 2'd0;
      end
      default: begin
        wr_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else if (cmd.finish) begin
      ex_r         <= ex_nxt;
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_b_r  <= res_b_nxt;
      wr_r     <= wr_nxt;
      skip_r   <= skip_nxt;
      res_ex_r <= ex_nxt;
      step_r   <= step_nxt;
      cost_r   <= cost_nxt;
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_tdata     = {2'b00, cost_r, step_r, res_ex_r, skip_r, wr_r, res_b_r};

  `ASSERT_NEXT_CYCLE(a_finish_valid, clk, rst_n, cmd.finish, out_tvalid, "result not presented")
  `ASSERT_NEXT_CYCLE(a_ex_hold, clk, rst_n, !cmd.finish, $stable(ex_r), "EX changed without result")
  `ASSERT_NEXT_CYCLE(a_index_step, clk, rst_n, cmd.finish && (op_r == OP_STI || op_r == OP_STD), out_tdata[35:34] != STEP_NONE, "index step lost")

endmodule

// ===== sv/c16alu_ctrl.sv =====
// Controller: sequences load, multiply, divide iterations and result write.
module c16alu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  c16alu_pkg::dp_stat_t stat,
  output c16alu_pkg::dp_cmd_t  cmd
);
  import c16alu_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.op_class)
          CLS_DIV: state_nxt = ST_DIV;
          CLS_MUL: state_nxt = ST_FINISH;
          default: state_nxt = stat.out_free ? ST_IDLE : ST_FINISH;
        endcase
      end
      ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DISPATCH: begin
        cmd.capture   = 1'b1;
        cmd.div_start = (stat.op_class == CLS_DIV);
        cmd.finish    = (stat.op_class == CLS_SIMPLE) && stat.out_free;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  `ASSERT_SAME_CYCLE(a_finish_free, clk, rst_n, cmd.finish, stat.out_free, "result overwrote a waiting item")
  `ASSERT_NEXT_CYCLE(a_load_dispatch, clk, rst_n, cmd.load, state_r == ST_DISPATCH, "accepted item not dispatched")
  `ASSERT_NEXT_CYCLE(a_div_exit, clk, rst_n, state_r == ST_DIV, state_r == ST_DIV || state_r == ST_FINISH, "divide left early")

endmodule

// ===== sv/cpu16_basic_op_alu.sv =====
// Top level of the 16-bit basic-opcode ALU with EX register.
//
//   channel   direction  tdata bits (low to high)
//   in_*      slave      command[4:0] operand_b[20:5] operand_a[36:21] zero[39:37]
//   out_*     master     result_b[15:0] write_b[16] skip_next[17] ex_value[33:18]
//                        index_step[35:34] cycle_cost[37:36] zero[39:38]
//
// One item at a time. SET/logic/shift/add/sub/IFx/ADX/SBX/STI/STD are written from dispatch,
// MUL and MLI after the product register (registered 17x17 multiplier), DIV/DVI/MOD/MDI
// after the divider, which retires 4 quotient bits per cycle.
// The result sits in an output register; the next item is accepted while it waits.
// A held output stalls only the write of the following result.
// Synchronous active-low reset clears EX, the controller and the output valid.
module cpu16_basic_op_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // command, operand_b, operand_a
  input  logic [c16alu_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_b, write_b, skip_next, ex_value, index_step, cycle_cost
  output logic [c16alu_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import c16alu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  c16alu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  c16alu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/tb_cpu16_basic_op_alu.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of cpu16_basic_op_alu: directed and random instructions vs. a predictor.
module tb_cpu16_basic_op_alu;
  import c16alu_pkg::*;

  typedef struct packed {
    logic        pause;
    logic [4:0]  cmd;
    logic [15:0] b;
    logic [15:0] a;
  } instr_t;

  typedef struct packed {
    logic [15:0] new_b;
    logic        wr;
    logic        skip;
    logic [15:0] ex;
    logic [1:0]  step;
    logic [1:0]  cost;
  } alu_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  instr_t      instr_q[$];
  alu_result_t want_q[$];
  instr_t      cur;
  alu_result_t res;
  alu_result_t got;
  alu_result_t want;
  logic [15:0] ex_model = '0;
  logic        drv_acc;
  int          gap_left = 0;
  int          stall_left = 0;
  int          issued = 0;
  int          sent_cnt = 0;
  int          recv_cnt = 0;
  int          fail_cnt = 0;

  cpu16_basic_op_alu dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic alu_result_t exec_instr(input logic [4:0] cmd, input logic [15:0] b,
                                             input logic [15:0] a, input logic [15:0] ex_in);
    alu_result_t        r;
    logic [31:0]        wide;
    logic signed [31:0] swide;
    int                 sb;
    int                 sa;
    int                 exs;
    int                 diff;
    longint             quo;
    sb = $signed(b);
    sa = $signed(a);
    exs = $signed(ex_in);
    r.new_b = b;
    r.wr = 1'b1;
    r.skip = 1'b0;
    r.ex = ex_in;
    r.step = STEP_NONE;
    r.cost = 2'd1;
    case (cmd)
      OP_SET: r.new_b = a;
      OP_ADD: begin
        wide = {16'h0, b} + {16'h0, a};
        r.new_b = wide[15:0];
        r.ex = wide[31:16];
        r.cost = 2'd2;
      end
      OP_SUB: begin
        r.new_b = b - a;
        r.ex = (b < a) ? 16'hFFFF : 16'h0000;
        r.cost = 2'd2;
      end
      OP_MUL: begin
        wide = {16'h0, b} * {16'h0, a};
        r.new_b = wide[15:0];
        r.ex = wide[31:16];
        r.cost = 2'd2;
      end
      OP_MLI: begin
        swide = sb * sa;
        r.new_b = swide[15:0];
        r.ex = swide[31:16];
        r.cost = 2'd2;
      end
      OP_DIV: begin
        r.cost = 2'd3;
        if (a != 16'h0) begin
          wide = {b, 16'h0} / {16'h0, a};
          r.new_b = wide[31:16];
          r.ex = wide[15:0];
        end else begin
          r.new_b = 16'h0;
          r.ex = 16'h0;
        end
      end
      OP_DVI: begin
        r.cost = 2'd3;
        if (sa != 0) begin
          diff = sb / sa;
          r.new_b = diff[15:0];
          quo = (longint'(sb) * 65536) / longint'(sa);
          r.ex = quo[15:0];
        end else begin
          r.new_b = 16'h0;
          r.ex = 16'h0;
        end
      end
      OP_MOD: begin
        r.cost = 2'd3;
        r.new_b = (a != 16'h0) ? b % a : 16'h0;
      end
      OP_MDI: begin
        r.cost = 2'd3;
        if (sa != 0) begin
          diff = sb % sa;
          r.new_b = diff[15:0];
        end else begin
          r.new_b = 16'h0;
        end
      end
      OP_AND: r.new_b = b & a;
      OP_BOR: r.new_b = b | a;
      OP_XOR: r.new_b = b ^ a;
      OP_SHR: begin
        wide = (a < 16'd32) ? ({b, 16'h0} >> a) : 32'h0;
        r.new_b = wide[31:16];
        r.ex = wide[15:0];
      end
      OP_ASR: begin
        swide = {b, 16'h0};
        if (a >= 16'd32) swide = b[15] ? 32'hFFFF_FFFF : 32'h0;
        else swide = swide >>> a;
        r.new_b = swide[31:16];
        r.ex = swide[15:0];
      end
      OP_SHL: begin
        wide = (a < 16'd32) ? ({16'h0, b} << a) : 32'h0;
        r.new_b = wide[15:0];
        r.ex = wide[31:16];
      end
      OP_IFB: begin r.wr = 1'b0; r.cost = 2'd2; r.skip = (b & a) == 16'h0; end
      OP_IFC: begin r.wr = 1'b0; r.cost = 2'd2; r.skip = (b & a) != 16'h0; end
      OP_IFE: begin r.wr = 1'b0; r.cost = 2'd2; r.skip = b != a; end
      OP_IFN: begin r.wr = 1'b0; r.cost = 2'd2; r.skip = b == a; end
      OP_IFG: begin r.wr = 1'b0; r.cost = 2'd2; r.skip = b <= a; end
      OP_IFA: begin r.wr = 1'b0; r.cost = 2'd2; r.skip = sb <= sa; end
      OP_IFL: begin r.wr = 1'b0; r.cost = 2'd2; r.skip = b >= a; end
      OP_IFU: begin r.wr = 1'b0; r.cost = 2'd2; r.skip = sb >= sa; end
      OP_ADX: begin
        wide = {16'h0, b} + {16'h0, a} + {16'h0, ex_in};
        r.new_b = wide[15:0];
        r.ex = (wide > 32'hFFFF) ? 16'h1 : 16'h0;
        r.cost = 2'd2;
      end
      OP_SBX: begin
        diff = int'(b) - int'(a) + exs;
        r.new_b = diff[15:0];
        r.ex = (diff < 0) ? 16'hFFFF : ((diff > 65535) ? 16'h1 : 16'h0);
        r.cost = 2'd2;
      end
      OP_STI: begin r.new_b = a; r.step = STEP_INC; r.cost = 2'd0; end
      OP_STD: begin r.new_b = a; r.step = STEP_DEC; r.cost = 2'd0; end
      default: r.wr = 1'b0;
    endcase
    if (!r.wr) r.new_b = b;
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      5: return 16'($urandom_range(0, 40));
      6: return 16'hFFFF - 16'($urandom_range(0, 3));
      7: return 16'h8000 ^ 16'($urandom_range(0, 3));
      8: begin
        case ($urandom_range(0, 4))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'h7FFF;
          3: return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void queue_instr(input logic [4:0] cmd, input logic [15:0] b,
                                      input logic [15:0] a, input logic pause);
    instr_t it;
    it.pause = pause;
    it.cmd = cmd;
    it.b = b;
    it.a = a;
    instr_q.push_back(it);
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_cnt++;
      if (fail_cnt <= 50)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    logic [15:0] b;
    logic [15:0] a;
    for (int c = 0; c < 32; c++) begin
      b = 16'hFFFF;
      a = 16'hFFFF;
      case (5'(c))
        OP_SUB, OP_SBX, OP_STI: b = 16'h0000;
        OP_MLI: begin b = 16'h8000; a = 16'h8000; end
        OP_DIV: begin b = 16'h1234; a = 16'h0000; end
        OP_DVI: b = 16'h8000;
        OP_MOD: a = 16'h0000;
        OP_MDI: begin b = 16'h8000; a = 16'h0000; end
        OP_ASR: begin b = 16'h8000; a = 16'd32; end
        OP_SHL: a = 16'd31;
        OP_IFB, OP_IFC, OP_IFE, OP_IFN, OP_IFG, OP_IFA, OP_IFL, OP_IFU: begin
          b = 16'h8000;
          a = 16'h7FFF;
        end
        default: ;
      endcase
      queue_instr(5'(c), b, a, 1'b0);
    end
    queue_instr(OP_DIV, 16'hFFFF, 16'h0001, 1'b0);
    queue_instr(OP_DVI, 16'h1234, 16'h0000, 1'b0);
    queue_instr(OP_MDI, 16'h8000, 16'hFFFF, 1'b0);
    queue_instr(OP_ASR, 16'h8000, 16'h0000, 1'b0);
    queue_instr(OP_SHR, 16'h8000, 16'd31, 1'b0);
    queue_instr(OP_ADD, 16'hFFFF, 16'h0001, 1'b0);
    queue_instr(OP_SBX, 16'hFFFF, 16'h0000, 1'b0);
    queue_instr(OP_SUB, 16'h0000, 16'h0001, 1'b0);
    queue_instr(OP_ADX, 16'hFFFF, 16'hFFFF, 1'b0);
    for (int i = 0; i < 1900; i++)
      queue_instr(5'($urandom_range(0, 31)), pick_word(), pick_word(),
                  (i == 500 || i == 1200));
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      drv_acc = in_tvalid && in_tready;
      if (drv_acc) begin
        res = exec_instr(cur.cmd, cur.b, cur.a, ex_model);
        ex_model = res.ex;
        want_q.push_back(res);
        sent_cnt <= sent_cnt + 1;
      end
      if (in_tvalid && !in_tready) begin
        // hold the item until it is taken
      end else if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (instr_q.size() > 0 &&
                   !(instr_q[0].pause && (drv_acc || sent_cnt != recv_cnt))) begin
        cur = instr_q.pop_front();
        in_tdata <= {3'b000, cur.a, cur.b, cur.cmd};
        in_tvalid <= 1'b1;
        gap_left = ((issued / 128) % 4 == 3) ? 0 : $urandom_range(0, 7);
        issued++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.new_b = out_tdata[15:0];
        got.wr = out_tdata[16];
        got.skip = out_tdata[17];
        got.ex = out_tdata[33:18];
        got.step = out_tdata[35:34];
        got.cost = out_tdata[37:36];
        if (want_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected item, expected none, actual %h", $time, out_tdata);
        end else begin
          want = want_q.pop_front();
          check_field("result_b", want.new_b, got.new_b);
          check_field("write_b", 16'(want.wr), 16'(got.wr));
          check_field("skip_next", 16'(want.skip), 16'(got.skip));
          check_field("ex_value", want.ex, got.ex);
          check_field("index_step", 16'(want.step), 16'(got.step));
          check_field("cycle_cost", 16'(want.cost), 16'(got.cost));
          check_field("zero pad", 16'h0, 16'(out_tdata[OUT_TDATA_W-1:38]));
        end
        recv_cnt <= recv_cnt + 1;
        stall_left = ((recv_cnt / 100) % 5 == 2) ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    @(posedge rst_n);
    while (instr_q.size() != 0 || in_tvalid || want_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_cnt == 0)
      $display("tb_cpu16_basic_op_alu: PASS");
    else
      $display("tb_cpu16_basic_op_alu: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_cpu16_basic_op_alu: FAIL");
    $finish;
  end

endmodule
